FILE: src/sse_pkg.sv
// shared types and constants of the sparse set engine
package sse_pkg;

  localparam int ID_W = 10;
  localparam int CNT_OUT_W = 11;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [ID_W-1:0]   item_id;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]      popped_id;
    logic                 set_was_empty;
    logic                 was_member;
    logic [CNT_OUT_W-1:0] member_count;
  } out_t;

endpackage

FILE: src/sse_ram.sv
// simple dual-port ram, one write and one registered read per cycle
module sse_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read before write on a shared address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/sse_seq.sv
// sequencer: member check, add, swap-remove, pop and clear over the two rams
module sse_seq #(
  parameter int UNIVERSE = 1024,
  parameter int IDX_W    = $clog2(UNIVERSE)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sse_pkg::in_t          in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sse_pkg::out_t         out_data,
  output logic [IDX_W-1:0]      slot_raddr,
  input  logic [IDX_W-1:0]      slot_rdata,
  output logic                  slot_we,
  output logic [IDX_W-1:0]      slot_waddr,
  output logic [IDX_W-1:0]      slot_wdata,
  output logic [IDX_W-1:0]      dense_raddr,
  input  logic [sse_pkg::ID_W-1:0] dense_rdata,
  output logic                  dense_we,
  output logic [IDX_W-1:0]      dense_waddr,
  output logic [sse_pkg::ID_W-1:0] dense_wdata
);

  import sse_pkg::*;

  localparam int CNT_W = $clog2(UNIVERSE + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_CHECK = 5'b00100,
    S_LAST  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  opcode_t         op_r, op_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  out_t            out_r, out_nxt;

  logic [CNT_W-1:0] cnt_m1;
  logic [31:0]      in_id_wide, id_wide, moved_wide;
  logic             in_range, hit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = out_r;

  assign cnt_m1     = count_r - 1'b1;
  assign in_id_wide = 32'(in_data.item_id);
  assign id_wide    = 32'(id_r);
  assign moved_wide = 32'(dense_rdata);
  assign in_range   = in_id_wide < 32'(UNIVERSE);

  assign slot_raddr = in_id_wide[IDX_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    slot_nxt    = slot_r;
    out_nxt     = out_r;
    hit         = 1'b0;
    slot_we     = 1'b0;
    slot_waddr  = id_wide[IDX_W-1:0];
    slot_wdata  = count_r[IDX_W-1:0];
    dense_we    = 1'b0;
    dense_waddr = count_r[IDX_W-1:0];
    dense_wdata = id_r;
    dense_raddr = cnt_m1[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_data.opcode;
          id_nxt  = in_data.item_id;
          out_nxt = '0;
          case (in_data.opcode)
            OP_ADD, OP_REMOVE: begin
              state_nxt = in_range ? S_LOOK : S_DONE;
            end
            OP_POP: begin
              if (count_r == '0) begin
                out_nxt.set_was_empty = 1'b1;
                state_nxt = S_DONE;
              end else begin
                // dense[count-1] is read on this edge
                state_nxt = S_LAST;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_LOOK: begin
        dense_raddr = slot_rdata;
        slot_nxt    = slot_rdata;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        // an unwritten slot entry falls through to not a member
        if ((32'(slot_r) < 32'(count_r)) && (dense_rdata == id_r)) begin
          hit = 1'b1;
        end
        out_nxt.was_member = hit;
        state_nxt = S_DONE;
        case (op_r)
          OP_ADD: begin
            if (!hit && (32'(count_r) < 32'(UNIVERSE))) begin
              dense_we  = 1'b1;
              slot_we   = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              state_nxt = S_LAST;
            end
          end
          default: ;
        endcase
      end
      S_LAST: begin
        count_nxt = cnt_m1;
        state_nxt = S_DONE;
        if (op_r == OP_POP) begin
          out_nxt.popped_id = dense_rdata;
        end else begin
          // move last member into the freed slot
          dense_we    = 1'b1;
          dense_waddr = slot_r;
          dense_wdata = dense_rdata;
          slot_we     = moved_wide < 32'(UNIVERSE);
          slot_waddr  = moved_wide[IDX_W-1:0];
          slot_wdata  = slot_r;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (state_nxt == S_DONE && state_r != S_DONE) begin
      out_nxt.member_count = CNT_OUT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    id_r   <= id_nxt;
    slot_r <= slot_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: src/sparse_set_engine.sv
// top level of the sparse set engine
//
//  channel | ports                          | beat
//  in      | in_valid in_ready in_data      | opcode, item_id
//  out     | out_valid out_ready out_data   | popped_id, set_was_empty, was_member, member_count
//
// the result beat is offered from the done state; clear, an empty pop and an out-of-range
// add/remove go there straight from idle, a pop by way of last, a member check (add/remove)
// by way of look and check, and a remove of a member by look, check and last, each read of
// the single-read-port rams being registered; in_ready rises the cycle after the beat is taken.
// reset empties the set at once (count to zero), no clearing pass over the rams.
// in_ready is low from acceptance until the result beat is taken; a stalled
// result holds its register.
module sparse_set_engine #(
  parameter int UNIVERSE = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sse_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sse_pkg::out_t out_data
);

  import sse_pkg::*;

  localparam int IDX_W = $clog2(UNIVERSE);

  logic [IDX_W-1:0] slot_raddr, slot_rdata, slot_waddr, slot_wdata;
  logic [IDX_W-1:0] dense_raddr, dense_waddr;
  logic [ID_W-1:0]  dense_rdata, dense_wdata;
  logic             slot_we, dense_we;

  sse_seq #(
    .UNIVERSE (UNIVERSE),
    .IDX_W    (IDX_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .slot_raddr  (slot_raddr),
    .slot_rdata  (slot_rdata),
    .slot_we     (slot_we),
    .slot_waddr  (slot_waddr),
    .slot_wdata  (slot_wdata),
    .dense_raddr (dense_raddr),
    .dense_rdata (dense_rdata),
    .dense_we    (dense_we),
    .dense_waddr (dense_waddr),
    .dense_wdata (dense_wdata)
  );

  // slot of each id
  sse_ram #(
    .DEPTH (UNIVERSE),
    .WIDTH (IDX_W),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // members packed in slots below the count
  sse_ram #(
    .DEPTH (UNIVERSE),
    .WIDTH (ID_W),
    .AW    (IDX_W)
  ) u_dense_ram (
    .clk   (clk),
    .we    (dense_we),
    .waddr (dense_waddr),
    .wdata (dense_wdata),
    .raddr (dense_raddr),
    .rdata (dense_rdata)
  );

endmodule
